// ----- sv/maxpool3x3_window_stream_fp16_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the fp16 3x3 max-pooling core
// Each macro expands to one labeled concurrent assertion clocked by clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAXPOOL3X3_WINDOW_STREAM_FP16_CORE_ASSERT_SVH
`define MAXPOOL3X3_WINDOW_STREAM_FP16_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MXP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mxp_pkg.sv -----
// ----------------------------------------------------------------------------
// mxp_pkg
// Types, constants and ordering helpers shared by the max-pooling core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mxp_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int FIFO_DEPTH     = 16;
  localparam int MAX_RES        = 4;
  localparam int POS_W          = 17;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 13;

  localparam logic [1:0] MODE_S2_NOPAD = 2'd0;
  localparam logic [1:0] MODE_S2_PAD   = 2'd1;
  localparam logic [1:0] MODE_S1_PAD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BOT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_EXT = 3'd4;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic vld;
    logic narrow;
    logic last;
  } win_t;

  typedef win_t [2:0] axis_win_t;

  typedef struct packed {
    logic [15:0] pooled;
    logic        plane_last;
  } res_t;

  function automatic logic [15:0] order_key(input logic [15:0] x);
    return x[15] ? ~x : (x | 16'h8000);
  endfunction

  function automatic logic [15:0] hmax(input logic [15:0] a, input logic [15:0] b);
    return (order_key(a) >= order_key(b)) ? a : b;
  endfunction

  function automatic logic [15:0] clamp_zero(input logic [15:0] x);
    return (order_key(x) <= 16'h8000) ? 16'h0000 : x;
  endfunction

  function automatic pos_t axis_count(input pos_t n, input logic [1:0] mode, input logic ext);
    pos_t full;
    full = '0;
    case (mode)
      MODE_S2_NOPAD: begin
        if (n >= pos_t'(3)) begin
          full = ((n - pos_t'(3)) >> 1) + pos_t'(1);
        end
        return full + pos_t'(ext & ~n[0]);
      end
      MODE_S2_PAD: begin
        return pos_t'(1) + ((n - pos_t'(2)) >> 1) + pos_t'(ext & n[0]);
      end
      default: begin
        return n;
      end
    endcase
  endfunction

  // Slot 0 is the leading partial window, slot 1 the full window and slot 2
  // the trailing partial window that position p completes along one axis.
  function automatic axis_win_t axis_win(input pos_t p, input pos_t n, input logic [1:0] mode,
                                         input logic ext, input pos_t cnt);
    axis_win_t w;
    pos_t      t_full;
    pos_t      t_tail;
    pos_t      lead;
    w      = '0;
    lead   = pos_t'(mode[0]);
    t_full = p - pos_t'(2) + lead;
    t_tail = p - pos_t'(1) + lead;
    if (mode == MODE_S1_PAD) begin
      w[0].vld    = (p == pos_t'(1));
      w[0].narrow = 1'b1;
      w[0].last   = (cnt == pos_t'(1));
      w[1].vld    = (p >= pos_t'(2));
      w[1].last   = (p == cnt);
      w[2].vld    = (p == n - pos_t'(1));
      w[2].narrow = 1'b1;
      w[2].last   = (n == cnt);
    end else begin
      w[0].vld    = mode[0] && (p == pos_t'(1));
      w[0].narrow = 1'b1;
      w[0].last   = (cnt == pos_t'(1));
      w[1].vld    = (p >= pos_t'(2)) && !t_full[0];
      w[1].last   = ((t_full >> 1) == cnt - pos_t'(1));
      w[2].vld    = ext && (p == n - pos_t'(1)) && (p >= pos_t'(1)) && !t_tail[0];
      w[2].narrow = 1'b1;
      w[2].last   = ((t_tail >> 1) == cnt - pos_t'(1));
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mxp_ram.sv -----
// ----------------------------------------------------------------------------
// mxp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mxp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/mxp_fifo.sv -----
// ----------------------------------------------------------------------------
// mxp_fifo
// Result queue that takes up to four results per cycle and gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mxp_fifo
  import mxp_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [2:0]                   push_cnt,
  input  wire res_t [MAX_RES-1:0]           push_data,
  input  wire logic                         pop,
  output res_t                              head,
  output logic                              not_empty,
  output logic      [$clog2(DEPTH+1)-1:0]   fill
);

  // DEPTH must be a power of two so that the pointers wrap on their own.
  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  assign wp_nxt   = wp_r + PW'(push_cnt);
  assign rp_nxt   = rp_r + PW'(pop);
  assign fill_nxt = fill_r + FW'(push_cnt) - FW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (3'(k) < push_cnt) begin
        mem_r[wp_r + PW'(k)] <= push_data[k];
      end
    end
  end

  assign head      = mem_r[rp_r];
  assign not_empty = (fill_r != '0);
  assign fill      = fill_r;

endmodule

`default_nettype wire

// ----- sv/maxpool3x3_window_stream_fp16_core.sv -----
// ----------------------------------------------------------------------------
// maxpool3x3_window_stream_fp16_core
// 3x3 max pooling over a raster stream of fp16 pixels of one channel plane.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock while in_stall is low. A pixel is
// registered together with a read of the two previous rows from two row RAMs
// of MAX_WIDTH entries; in the next cycle the windows that the pixel completes
// (up to four) are formed and written into a 16-entry result queue, which
// gives one result per clock while out_stall is low. The input stalls while
// the queue lacks room for the results of two pixels, which happens only on
// rows that complete more than one window per pixel (the last row in stride-1
// mode) or when the output side stalls.
`timescale 1ns / 1ps
`default_nettype none
`include "maxpool3x3_window_stream_fp16_core_assert.svh"

module maxpool3x3_window_stream_fp16_core
  import mxp_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [15:0]           in_pixel,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [15:0]           out_pooled,
  output logic                       out_plane_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int FW = $clog2(FIFO_DEPTH + 1);

  logic [12:0] height_r;
  logic [10:0] width_r;
  logic [1:0]  mode_r;
  logic        pad_bot_r;
  logic        right_ext_r;
  logic        cfg_hit;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [RW:0]   row_inc;
  logic [CW:0]   col_inc;

  pos_t       h_eff, w_eff, rows_cnt, cols_cnt;
  logic [1:0] mode_eff;

  logic          s1_v_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic [15:0]   s1_px_r;

  logic [15:0] row_a_rd, row_b_rd;
  logic [15:0] v3, v2;
  logic [15:0] cmax0_r, cmax1_r, pmax0_r, pmax1_r;
  logic [15:0] val_ff, val_fn, val_nf, val_nn;

  axis_win_t          rwin, cwin;
  res_t [MAX_RES-1:0] push_data;
  logic [2:0]         res_cnt;
  logic [2:0]         push_cnt;

  res_t          head;
  logic [FW-1:0] fill;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_HEIGHT || cfg_index == REG_WIDTH ||
                                   cfg_index == REG_MODE || cfg_index == REG_PAD_BOT ||
                                   cfg_index == REG_RIGHT_EXT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r    <= 13'd2;
      width_r     <= 11'd2;
      mode_r      <= MODE_S2_NOPAD;
      pad_bot_r   <= 1'b0;
      right_ext_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEIGHT:    height_r    <= cfg_data;
        REG_WIDTH:     width_r     <= cfg_data[10:0];
        REG_MODE:      mode_r      <= cfg_data[1:0];
        REG_PAD_BOT:   pad_bot_r   <= cfg_data[0];
        REG_RIGHT_EXT: right_ext_r <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    if (pos_t'(height_r) < pos_t'(2)) begin
      h_eff = pos_t'(2);
    end else if (pos_t'(height_r) > pos_t'(MAX_HEIGHT)) begin
      h_eff = pos_t'(MAX_HEIGHT);
    end else begin
      h_eff = pos_t'(height_r);
    end
    if (pos_t'(width_r) < pos_t'(2)) begin
      w_eff = pos_t'(2);
    end else if (pos_t'(width_r) > pos_t'(MAX_WIDTH)) begin
      w_eff = pos_t'(MAX_WIDTH);
    end else begin
      w_eff = pos_t'(width_r);
    end
  end

  assign mode_eff = (mode_r == MODE_S2_NOPAD || mode_r == MODE_S2_PAD) ? mode_r : MODE_S1_PAD;
  assign rows_cnt = axis_count(h_eff, mode_eff, pad_bot_r);
  assign cols_cnt = axis_count(w_eff, mode_eff, right_ext_r);

  assign accept = in_valid && !in_stall;
  assign in_stall = (FW'(fill) + (s1_v_r ? FW'(MAX_RES) : FW'(0)) >
                     FW'(FIFO_DEPTH - MAX_RES));

  always_comb begin
    if (pos_t'(row_r) >= h_eff || pos_t'(col_r) >= w_eff) begin
      cur_row = '0;
      cur_col = '0;
    end else begin
      cur_row = row_r;
      cur_col = col_r;
    end
    row_inc = (RW + 1)'(cur_row) + (RW + 1)'(1);
    col_inc = (CW + 1)'(cur_col) + (CW + 1)'(1);
    row_nxt = cur_row;
    col_nxt = col_inc[CW-1:0];
    if (pos_t'(col_inc) >= w_eff) begin
      col_nxt = '0;
      row_nxt = (pos_t'(row_inc) >= h_eff) ? '0 : row_inc[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (cfg_hit) begin
        row_r <= '0;
        col_r <= '0;
      end else if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r <= cur_row;
      s1_col_r <= cur_col;
      s1_px_r  <= in_pixel;
    end
  end

  mxp_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_row_a (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (accept),
    .raddr (cur_col),
    .rdata (row_a_rd)
  );

  mxp_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_row_b (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (row_a_rd),
    .re    (accept),
    .raddr (cur_col),
    .rdata (row_b_rd)
  );

  assign v3 = hmax(hmax(row_b_rd, row_a_rd), s1_px_r);
  assign v2 = hmax(row_a_rd, s1_px_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmax0_r <= '0;
      cmax1_r <= '0;
      pmax0_r <= '0;
      pmax1_r <= '0;
    end else if (s1_v_r) begin
      cmax0_r <= v3;
      cmax1_r <= cmax0_r;
      pmax0_r <= v2;
      pmax1_r <= pmax0_r;
    end
  end

  assign val_ff = hmax(hmax(v3, cmax0_r), cmax1_r);
  assign val_fn = clamp_zero(hmax(v3, cmax0_r));
  assign val_nf = clamp_zero(hmax(hmax(v2, pmax0_r), pmax1_r));
  assign val_nn = clamp_zero(hmax(v2, pmax0_r));

  assign rwin = axis_win(pos_t'(s1_row_r), h_eff, mode_eff, pad_bot_r, rows_cnt);
  assign cwin = axis_win(pos_t'(s1_col_r), w_eff, mode_eff, right_ext_r, cols_cnt);

  // Results leave in ascending window row, then window column.
  always_comb begin
    push_data = '0;
    res_cnt   = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rwin[i].vld && cwin[j].vld && res_cnt < 3'(MAX_RES)) begin
          case ({rwin[i].narrow, cwin[j].narrow})
            2'b00:   push_data[res_cnt[1:0]].pooled = val_ff;
            2'b01:   push_data[res_cnt[1:0]].pooled = val_fn;
            2'b10:   push_data[res_cnt[1:0]].pooled = val_nf;
            default: push_data[res_cnt[1:0]].pooled = val_nn;
          endcase
          push_data[res_cnt[1:0]].plane_last = rwin[i].last && cwin[j].last;
          res_cnt = res_cnt + 3'd1;
        end
      end
    end
  end

  assign push_cnt = s1_v_r ? res_cnt : 3'd0;

  mxp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .pop       (out_valid && !out_stall),
    .head      (head),
    .not_empty (out_valid),
    .fill      (fill)
  );

  assign out_pooled     = head.pooled;
  assign out_plane_last = head.plane_last;

  `MXP_ASSERT_NOW(a_queue_room, 1'b1, (fill + (s1_v_r ? FW'(MAX_RES) : FW'(0))) <= FW'(FIFO_DEPTH), "result queue may overflow")
  `MXP_ASSERT_NOW(a_col_range, s1_v_r, pos_t'(s1_col_r) < w_eff, "column position out of range")
  `MXP_ASSERT_NOW(a_row_range, s1_v_r, pos_t'(s1_row_r) < h_eff, "row position out of range")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the fp16 3x3 max-pooling stream core. A scoreboard
// predicts every pooled result from accepted pixels across several plane
// shapes and pooling modes, with random idling on the pixel and result sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mxp_pkg::*;

  class pool_scoreboard;
    logic [12:0] height;
    logic [10:0] width;
    logic [1:0]  mode;
    logic        pad_bot;
    logic        right_ext;
    logic [15:0] row_a [1024];
    logic [15:0] row_b [1024];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [15:0] col3_prev [2];
    logic [15:0] col2_prev [2];
    res_t        pending [$];
    int          mismatches;
    int          results_seen;

    function new();
      height = 2; width = 2; mode = MODE_S2_NOPAD; pad_bot = 0; right_ext = 0;
      row_pos = 0; col_pos = 0; mismatches = 0; results_seen = 0;
      col3_prev[0] = 0; col3_prev[1] = 0; col2_prev[0] = 0; col2_prev[1] = 0;
      foreach (row_a[i]) begin
        row_a[i] = 0; row_b[i] = 0;
      end
    endfunction

    function logic [15:0] rank(logic [15:0] x);
      return x[15] ? ~x : (x | 16'h8000);
    endfunction

    function logic [15:0] fmax(logic [15:0] a, logic [15:0] b);
      return (rank(a) >= rank(b)) ? a : b;
    endfunction

    function logic [15:0] floor_zero(logic [15:0] x);
      return (rank(x) <= 16'h8000) ? 16'h0000 : x;
    endfunction

    function int unsigned window_total(int unsigned n, int unsigned m, bit ext);
      if (m == 2) return n;
      if (m == 1) return 1 + (n - 2) / 2 + ((ext && n[0]) ? 1 : 0);
      return (n >= 3 ? (n - 3) / 2 + 1 : 0) + ((ext && !n[0]) ? 1 : 0);
    endfunction

    function int axis_hits(int unsigned p, int unsigned n, int unsigned m, bit ext,
                           output int unsigned idx[3], output bit nar[3]);
      int k;
      k = 0;
      if (m == 2) begin
        if (p == 1) begin idx[k] = 0; nar[k] = 1; k++; end
        if (p >= 2) begin idx[k] = p - 1; nar[k] = 0; k++; end
        if (p == n - 1) begin idx[k] = n - 1; nar[k] = 1; k++; end
        return k;
      end
      if (m == 1 && p == 1) begin idx[k] = 0; nar[k] = 1; k++; end
      if (p >= 2 && ((p - 2 + m) % 2 == 0)) begin
        idx[k] = (p - 2 + m) / 2; nar[k] = 0; k++;
      end
      if (ext && p == n - 1 && p >= 1 && ((p - 1 + m) % 2 == 0)) begin
        idx[k] = (p - 1 + m) / 2; nar[k] = 1; k++;
      end
      return k;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_HEIGHT:    height = val;
        REG_WIDTH:     width = val[10:0];
        REG_MODE:      mode = val[1:0];
        REG_PAD_BOT:   pad_bot = val[0];
        REG_RIGHT_EXT: right_ext = val[0];
        default:       return;
      endcase
      row_pos = 0; col_pos = 0;
    endfunction

    function void note_pixel(logic [15:0] px);
      int unsigned h, w, m, r, c, rows_out, cols_out;
      int unsigned ri[3], ci[3];
      bit rn[3], cn[3];
      int nr, nc, n;
      logic [15:0] v3, v2, cur, mx;
      res_t item;
      h = (height < 2) ? 2 : (height > 4096 ? 4096 : height);
      w = (width < 2) ? 2 : (width > 1024 ? 1024 : width);
      m = (mode >= 2) ? 2 : mode;
      r = row_pos; c = col_pos;
      if (r >= h || c >= w) begin r = 0; c = 0; end
      rows_out = window_total(h, m, pad_bot);
      cols_out = window_total(w, m, right_ext);
      v3 = fmax(fmax(row_b[c], row_a[c]), px);
      v2 = fmax(row_a[c], px);
      nr = axis_hits(r, h, m, pad_bot, ri, rn);
      nc = axis_hits(c, w, m, right_ext, ci, cn);
      n = 0;
      for (int i = 0; i < nr; i++) begin
        cur = rn[i] ? v2 : v3;
        for (int j = 0; j < nc && n < 4; j++) begin
          mx = fmax(cur, rn[i] ? col2_prev[0] : col3_prev[0]);
          if (!cn[j]) mx = fmax(mx, rn[i] ? col2_prev[1] : col3_prev[1]);
          if (rn[i] || cn[j]) mx = floor_zero(mx);
          item.pooled = mx;
          item.plane_last = (ri[i] == rows_out - 1) && (ci[j] == cols_out - 1);
          pending.push_back(item);
          n++;
        end
      end
      col3_prev[1] = col3_prev[0]; col3_prev[0] = v3;
      col2_prev[1] = col2_prev[0]; col2_prev[0] = v2;
      row_b[c] = row_a[c]; row_a[c] = px;
      c++;
      if (c >= w) begin
        c = 0; r++;
        if (r >= h) r = 0;
      end
      row_pos = r; col_pos = c;
    endfunction

    function void check_result(logic [15:0] pooled, logic last);
      res_t exp_item;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h last %b", pooled, last);
        return;
      end
      exp_item = pending.pop_front();
      if (exp_item.pooled !== pooled || exp_item.plane_last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected %h last %b, got %h last %b",
                   exp_item.pooled, exp_item.plane_last, pooled, last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [15:0]           in_pixel;
  logic                  out_valid;
  logic                  out_stall;
  logic [15:0]           out_pooled;
  logic                  out_plane_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pool_scoreboard sb;
  bit             idle_enable;
  int             pixels_sent;
  int             planes_run;

  maxpool3x3_window_stream_fp16_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pooled(out_pooled), .out_plane_last(out_plane_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_pooled, out_plane_last);
  end

  initial begin : sink_idle
    int burst;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (burst) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic send_pixel(logic [15:0] px);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7C00;
      3: return 16'hFC00;
      4: return 16'h7E00;
      5: return 16'hFE00;
      6: return {1'b1, 15'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  // Large planes are cut short; the next register write starts a new plane.
  task automatic run_plane(int h, int w, int m, bit pb, bit pr, bit directed);
    int count;
    drain();
    write_cfg(REG_HEIGHT, CFG_DATA_W'(h));
    write_cfg(REG_WIDTH, CFG_DATA_W'(w));
    write_cfg(REG_MODE, CFG_DATA_W'(m));
    write_cfg(REG_PAD_BOT, CFG_DATA_W'(pb));
    write_cfg(REG_RIGHT_EXT, CFG_DATA_W'(pr));
    cfg_valid <= 0;
    count = ((h < 2) ? 2 : (h > 4096 ? 4096 : h)) * ((w < 2) ? 2 : (w > 1024 ? 1024 : w));
    if (count > 48) count = 48;
    for (int i = 0; i < count; i++) begin
      if (directed) send_pixel((i % 3 == 0) ? 16'hFFFF : ((i % 3 == 1) ? 16'h8001 : 16'h7BFF));
      else send_pixel(rand_pixel());
    end
    in_valid <= 0;
    planes_run++;
  endtask

  initial begin
    int h, w;
    sb = new();
    idle_enable = 1;
    pixels_sent = 0;
    planes_run = 0;
    rst_n = 0;
    in_valid = 0;
    in_pixel = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    run_plane(3, 3, 0, 0, 0, 1);
    run_plane(2, 2, 0, 0, 0, 1);
    run_plane(2, 2, 0, 1, 1, 1);
    run_plane(3, 3, 1, 1, 1, 1);
    run_plane(3, 3, 3, 0, 0, 1);
    while (pixels_sent < 300) begin
      h = $urandom_range(2, 6);
      w = $urandom_range(2, 7);
      if (pixels_sent > 240) idle_enable = 0;
      run_plane(h, w, $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1), 0);
    end
    run_plane(0, 1, 2, 1, 1, 0);
    run_plane(8191, 3, 1, 1, 1, 0);
    drain();
    $display("Ran %0d planes, %0d pixels, %0d results checked.",
             planes_run, pixels_sent, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
